@@ rtl/cpt_pkg.sv @@
// Shared constants, types and the sine table generator for the Clarke/Park transform.
package cpt_pkg;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned TRIG_W  = 16;   // signed Q15 sine/cosine
  localparam int unsigned LUT_W   = 15;   // unsigned quarter-wave entry

  localparam logic [16:0] INV_SQRT3_Q16 = 17'd37837;
  localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
  localparam logic [15:0] QUARTER_TURN  = 16'd16384;

  // Stage enables handed to the trig unit.
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

  // Quarter-wave sine entry k of a 2^tbl_bits table, Q15, built at elaboration.
  function automatic logic [LUT_W-1:0] sine_entry(input int unsigned tbl_bits,
                                                  input int unsigned k);
    logic        [63:0] x;
    logic        [63:0] x2;
    logic        [63:0] term;
    logic        [63:0] prod;
    logic        [63:0] e;
    logic signed [63:0] sum;
    int unsigned        n;
    x    = (HALF_PI_Q30 * 64'(k)) >> tbl_bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (n = 1; n <= 6; n++) begin
      prod = (term * x2) >> 30;
      case (n)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        default: term = prod / 64'd156;
      endcase
      if (n[0]) sum = sum - signed'(term);
      else      sum = sum + signed'(term);
    end
    if (sum < 0) sum = '0;
    e = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (e > 64'd32767) e = 64'd32767;
    return e[LUT_W-1:0];
  endfunction

endpackage

@@ rtl/cpt_stream_if.sv @@
// Valid/ready stream interfaces for the current sample and result words.
interface cpt_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] phase_a_current;
  logic signed [SAMPLE_WIDTH-1:0] phase_b_current;
  logic        [15:0]             electrical_angle;

  modport source (output valid, phase_a_current, phase_b_current, electrical_angle,
                  input ready);
  modport sink   (input valid, phase_a_current, phase_b_current, electrical_angle,
                  output ready);
endinterface

interface cpt_out_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] alpha_current;
  logic signed [SAMPLE_WIDTH-1:0] beta_current;
  logic signed [SAMPLE_WIDTH-1:0] direct_current;
  logic signed [SAMPLE_WIDTH-1:0] quadrature_current;

  modport source (output valid, alpha_current, beta_current, direct_current,
                  quadrature_current, input ready);
  modport sink   (input valid, alpha_current, beta_current, direct_current,
                  quadrature_current, output ready);
endinterface

@@ rtl/cpt_sincos.sv @@
// Two-stage sine/cosine unit: quarter-wave table lookup, then linear interpolation.
module cpt_sincos import cpt_pkg::*; #(
  parameter int unsigned TABLE_BITS = 8
) (
  input  logic                     clk_i,
  input  stage_en_t                en_i,
  input  logic [ANGLE_W-1:0]       angle_i,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  localparam int unsigned TBL_N  = 1 << TABLE_BITS;
  localparam int unsigned FRAC_W = 14 - TABLE_BITS;
  localparam int unsigned IDX_W  = TABLE_BITS + 1;
  localparam int unsigned IP_W   = LUT_W + FRAC_W + 1;
  localparam logic [IP_W-1:0]  IP_HALF = IP_W'(1) << (FRAC_W - 1);
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(TBL_N);

  logic [LUT_W-1:0] lut [TBL_N+1];

  for (genvar k = 0; k <= TBL_N; k++) begin : g_lut
    assign lut[k] = sine_entry(TABLE_BITS, k);
  end

  // index 0 is sine, index 1 is cosine (angle plus a quarter turn)
  logic        [LUT_W-1:0]  base_q [2];
  logic        [LUT_W-1:0]  diff_q [2];
  logic        [FRAC_W-1:0] frac_q [2];
  logic                     neg_q  [2];
  logic signed [TRIG_W-1:0] trig_q [2];

  for (genvar ch = 0; ch < 2; ch++) begin : g_ch
    logic [ANGLE_W-1:0] ang;
    logic [14:0]        pos;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   idx_nx;
    logic [LUT_W-1:0]   base;
    logic [LUT_W-1:0]   nxt;
    logic [IP_W-1:0]    ip;
    logic [TRIG_W-1:0]  mag;

    assign ang    = angle_i + ((ch == 1) ? QUARTER_TURN : '0);
    // odd quadrants run the table backwards
    assign pos    = ang[14] ? (15'(QUARTER_TURN) - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    assign idx    = pos[14:FRAC_W];
    assign idx_nx = (idx == IDX_TOP) ? idx : idx + 1'b1;
    assign base   = lut[idx];
    assign nxt    = lut[idx_nx];

    always_ff @(posedge clk_i) begin
      if (en_i.s1) begin
        base_q[ch] <= base;
        diff_q[ch] <= (nxt >= base) ? nxt - base : '0;
        frac_q[ch] <= pos[FRAC_W-1:0];
        neg_q[ch]  <= ang[15];
      end
    end

    assign ip  = (IP_W'(diff_q[ch]) * IP_W'(frac_q[ch]) + IP_HALF) >> FRAC_W;
    assign mag = TRIG_W'(base_q[ch]) + ip[TRIG_W-1:0];

    always_ff @(posedge clk_i) begin
      if (en_i.s2) begin
        trig_q[ch] <= neg_q[ch] ? -signed'(mag) : signed'(mag);
      end
    end
  end

  assign sin_o = trig_q[0];
  assign cos_o = trig_q[1];

endmodule

@@ rtl/clarke_park_current_transform.sv @@
// Clarke/Park current transform: four-stage pipeline from phase currents to d/q currents.
// Takes one word per cycle while the output does not stall and returns one result word
// per input word, in order. Each word passes through the stages in turn:
// stage 1 does the sine table lookup and the 1/sqrt(3) multiply for beta, stage 2
// interpolates sine/cosine and rounds beta, stage 3 forms the four Park products and
// stage 4 sums, rounds and saturates them. Backpressure stalls the pipeline from the
// output end only, so empty stages still fill while a finished result waits. The sine
// table is a constant of 2^SINE_TABLE_BITS + 1 entries; there is no start-up sweep.
module clarke_park_current_transform import cpt_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = 8,
  parameter int unsigned SAMPLE_WIDTH    = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  cpt_in_if.sink    in_i,
  cpt_out_if.source out_o
);

  localparam int unsigned W      = SAMPLE_WIDTH;
  localparam int unsigned BSUM_W = W + 2;
  localparam int unsigned BPRD_W = BSUM_W + 18;
  localparam int unsigned PRD_W  = W + TRIG_W;
  localparam int unsigned SAT_W  = BPRD_W;

  localparam logic signed [SAT_W-1:0] B_RND = SAT_W'(1) << 15;
  localparam logic signed [SAT_W-1:0] P_RND = SAT_W'(1) << 14;
  localparam logic signed [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sat_w(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-W:0] hi;
    hi = v[SAT_W-1:W-1];
    if ((&hi) || !(|hi)) return v[W-1:0];
    return v[SAT_W-1] ? W_MIN : W_MAX;
  endfunction

  // stage valids and advance terms
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_q || out_o.ready;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_i.ready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_i.valid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  // stage 1: beta numerator times 1/sqrt(3)
  logic signed [BSUM_W-1:0] bsum;
  logic signed [W-1:0]      alpha1_q;
  logic signed [BPRD_W-1:0] bprod1_q;

  assign bsum = BSUM_W'(in_i.phase_a_current) + (BSUM_W'(in_i.phase_b_current) <<< 1);

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      alpha1_q <= in_i.phase_a_current;
      bprod1_q <= BPRD_W'(bsum) * BPRD_W'(signed'({1'b0, INV_SQRT3_Q16}));
    end
  end

  // sine/cosine, results line up with stage 2
  stage_en_t               trig_en;
  logic signed [TRIG_W-1:0] sin2, cos2;

  assign trig_en.s1 = adv1;
  assign trig_en.s2 = adv2;

  cpt_sincos #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_sincos (
    .clk_i   (clk_i),
    .en_i    (trig_en),
    .angle_i (in_i.electrical_angle),
    .sin_o   (sin2),
    .cos_o   (cos2)
  );

  // stage 2: round and saturate beta
  logic signed [SAT_W-1:0] beta_rnd;
  logic signed [W-1:0]     alpha2_q, beta2_q;

  assign beta_rnd = (bprod1_q + B_RND) >>> 16;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      alpha2_q <= alpha1_q;
      beta2_q  <= sat_w(beta_rnd);
    end
  end

  // stage 3: Park products
  logic signed [W-1:0]     alpha3_q, beta3_q;
  logic signed [PRD_W-1:0] ac_q, bs_q, bc_q, as_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      alpha3_q <= alpha2_q;
      beta3_q  <= beta2_q;
      ac_q     <= PRD_W'(alpha2_q) * PRD_W'(cos2);
      bs_q     <= PRD_W'(beta2_q)  * PRD_W'(sin2);
      bc_q     <= PRD_W'(beta2_q)  * PRD_W'(cos2);
      as_q     <= PRD_W'(alpha2_q) * PRD_W'(sin2);
    end
  end

  // stage 4: sum, round half up, saturate
  logic signed [SAT_W-1:0] d_rnd, q_rnd;
  logic signed [W-1:0]     alpha4_q, beta4_q, d4_q, q4_q;

  assign d_rnd = (SAT_W'(ac_q) + SAT_W'(bs_q) + P_RND) >>> 15;
  assign q_rnd = (SAT_W'(bc_q) - SAT_W'(as_q) + P_RND) >>> 15;

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      alpha4_q <= alpha3_q;
      beta4_q  <= beta3_q;
      d4_q     <= sat_w(d_rnd);
      q4_q     <= sat_w(q_rnd);
    end
  end

  assign out_o.valid              = v4_q;
  assign out_o.alpha_current      = alpha4_q;
  assign out_o.beta_current       = beta4_q;
  assign out_o.direct_current     = d4_q;
  assign out_o.quadrature_current = q4_q;

  // a full pipeline with a stalled output must refuse new words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && v4_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while pipeline full and stalled");

  // a word never waits behind an empty stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !v2_q) |=> v2_q)
    else $error("stage 1 word failed to advance into empty stage 2");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && adv4) |=> out_o.valid)
    else $error("stage 3 word lost on its way to the output");

  // an accepted word always lands in stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v1_q)
    else $error("accepted word missing from stage 1");

endmodule

@@ test/cpt_current_checker.sv @@
// Watches the sample and result channels, predicts each result word and compares it.
`timescale 1ns / 100ps

module cpt_current_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  cpt_in_if           sample_i,
  cpt_out_if          result_i,
  output int unsigned err_count_o,
  output int unsigned matched_o
);

  localparam int TBL_BITS  = 8;
  localparam int TBL_LEN   = 1 << TBL_BITS;
  localparam int FRAC_BITS = 14 - TBL_BITS;

  typedef longint unsigned u64_t;

  localparam u64_t   HALF_PI_FIX = 64'd1686629713;  // Q30
  localparam longint RECIP_SQRT3 = 37837;           // Q16

  typedef struct packed {
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic signed [15:0] direct;
    logic signed [15:0] quad;
  } dq_word_t;

  int          sine_q15 [0:TBL_LEN];
  dq_word_t    dq_expected_q [$];
  int unsigned n_errors;
  int unsigned n_matched;

  assign err_count_o = n_errors;
  assign matched_o   = n_matched;

  // Quarter-wave table from a Taylor series to x^13, truncating after every step.
  function automatic void fill_sine_q15();
    u64_t   x;
    u64_t   x2;
    u64_t   term;
    u64_t   scaled;
    longint sum;
    int     k;
    int     n;
    for (k = 0; k <= TBL_LEN; k++) begin
      x    = (HALF_PI_FIX * u64_t'(k)) / u64_t'(TBL_LEN);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - longint'(term);
        else            sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      scaled = (u64_t'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (scaled > 64'd32767) scaled = 64'd32767;
      sine_q15[k] = int'(scaled);
    end
  endfunction

  function automatic int quarter_sine(input int p);
    int idx;
    int frac;
    int diff;
    idx  = (p >> FRAC_BITS) & (2 * TBL_LEN - 1);
    frac = p & ((1 << FRAC_BITS) - 1);
    if (idx >= TBL_LEN) return sine_q15[TBL_LEN];
    diff = sine_q15[idx + 1] - sine_q15[idx];
    if (diff < 0) diff = 0;
    return sine_q15[idx] + ((diff * frac + (1 << (FRAC_BITS - 1))) >> FRAC_BITS);
  endfunction

  function automatic longint sine_of(input logic [15:0] ang);
    int p;
    int v;
    p = int'(ang[13:0]);
    v = quarter_sine(ang[14] ? 16384 - p : p);
    return ang[15] ? -longint'(v) : longint'(v);
  endfunction

  // floor((v + 2^(s-1)) / 2^s): halves round toward plus infinity
  function automatic longint round_shr(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767)  return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic dq_word_t predict_dq(input logic signed [15:0] ia,
                                          input logic signed [15:0] ib,
                                          input logic        [15:0] ang);
    dq_word_t    w;
    longint      a;
    longint      b;
    longint      bt;
    longint      s;
    longint      c;
    logic [15:0] ang_c;
    a       = longint'(ia);
    b       = longint'(ib);
    ang_c   = ang + 16'd16384;
    s       = sine_of(ang);
    c       = sine_of(ang_c);
    w.alpha = ia;
    w.beta  = clamp16(round_shr((a + 2 * b) * RECIP_SQRT3, 16));
    bt      = longint'(w.beta);
    w.direct = clamp16(round_shr(a * c + bt * s, 15));
    w.quad   = clamp16(round_shr(bt * c - a * s, 15));
    return w;
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input int unsigned idx,
                             input logic signed [15:0] got,
                             input logic signed [15:0] want);
    if (got !== want)
      report_error($sformatf("word %0d %s: got %0d, want %0d", idx, name, got, want));
  endtask

  initial begin
    n_errors  = 0;
    n_matched = 0;
    fill_sine_q15();
  end

  always @(posedge clk_i) begin
    dq_word_t want;
    if (rst_ni) begin
      if (sample_i.valid && sample_i.ready)
        dq_expected_q.push_back(predict_dq(sample_i.phase_a_current,
                                           sample_i.phase_b_current,
                                           sample_i.electrical_angle));
      if (result_i.valid && result_i.ready) begin
        if (dq_expected_q.size() == 0) begin
          report_error($sformatf("result word with nothing pending: %0d %0d %0d %0d",
                                 result_i.alpha_current, result_i.beta_current,
                                 result_i.direct_current, result_i.quadrature_current));
        end else begin
          want = dq_expected_q.pop_front();
          check_field("alpha", n_matched, result_i.alpha_current, want.alpha);
          check_field("beta", n_matched, result_i.beta_current, want.beta);
          check_field("d", n_matched, result_i.direct_current, want.direct);
          check_field("q", n_matched, result_i.quadrature_current, want.quad);
          n_matched++;
        end
      end
    end
  end

endmodule

@@ test/tb_clarke_park_current_transform.sv @@
// Stimulus and verdict for the Clarke/Park current transform, checked by cpt_current_checker.
`timescale 1ns / 100ps

module tb_clarke_park_current_transform;

  localparam int N_RANDOM   = 530;
  localparam int HOLD_AT    = 150;
  localparam int DRAIN_AT   = 300;
  localparam int QUIET_FROM = 430;
  localparam int HOLD_LEN   = 80;
  localparam int TAIL_WAIT  = 12;

  logic        clk;
  logic        rst_n;
  bit          idle_en;
  bit          long_hold_req;
  bit          hold_taken;
  int          hold_cycles;
  int unsigned n_sent;
  int unsigned n_errors;
  int unsigned n_matched;

  cpt_in_if  #(.SAMPLE_WIDTH(16)) sample_if ();
  cpt_out_if #(.SAMPLE_WIDTH(16)) result_if ();

  clarke_park_current_transform #(
    .SINE_TABLE_BITS(8),
    .SAMPLE_WIDTH   (16)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (sample_if.sink),
    .out_o (result_if.source)
  );

  cpt_current_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .sample_i   (sample_if),
    .result_i   (result_if),
    .err_count_o(n_errors),
    .matched_o  (n_matched)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb_clarke_park_current_transform: done, errors");
    $finish;
  end

  // Offer one sample word and hold it until taken.
  task automatic send_word(input logic signed [15:0] ia, input logic signed [15:0] ib,
                           input logic [15:0] ang);
    sample_if.valid            <= 1'b1;
    sample_if.phase_a_current  <= ia;
    sample_if.phase_b_current  <= ib;
    sample_if.electrical_angle <= ang;
    do @(posedge clk); while (!sample_if.ready);
    n_sent++;
  endtask

  task automatic sender_gap();
    if (idle_en && $urandom_range(0, 3) == 0) begin
      sample_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] pick_current();
    case ($urandom_range(0, 11))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return 16'sd0;
      3:       return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly uniform angles, some within two steps of a quadrant boundary.
  function automatic logic [15:0] pick_angle();
    logic [15:0] edge_ang;
    if ($urandom_range(0, 5) == 0) begin
      edge_ang = {2'($urandom_range(0, 3)), 14'd0};
      return edge_ang + 16'($urandom_range(0, 4)) - 16'd2;
    end
    return 16'($urandom);
  endfunction

  // Result side: random stall bursts plus one long hold-off.
  initial begin
    result_if.ready <= 1'b0;
    hold_taken = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        result_if.ready <= 1'b0;
        for (hold_cycles = 0; hold_cycles < HOLD_LEN; hold_cycles++) @(posedge clk);
        result_if.ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk);
        @(posedge clk);
        result_if.ready <= 1'b1;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int i;
    n_sent        = 0;
    idle_en       = 1'b1;
    long_hold_req = 1'b0;
    rst_n         = 1'b0;
    sample_if.valid            <= 1'b0;
    sample_if.phase_a_current  <= '0;
    sample_if.phase_b_current  <= '0;
    sample_if.electrical_angle <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, quadrant edges, table fractions, saturation
    send_word(16'sd0, 16'sd0, 16'd0);
    send_word(16'sd32767, 16'sd0, 16'd0);
    send_word(-16'sd32768, 16'sd0, 16'd16384);
    send_word(16'sd0, 16'sd32767, 16'd32768);
    send_word(16'sd0, -16'sd32768, 16'd49152);
    send_word(16'sd32767, 16'sd32767, 16'd8192);      // beta and d clip high
    send_word(-16'sd32768, -16'sd32768, 16'd8192);    // beta and d clip low
    send_word(16'sd32767, 16'sd32767, 16'd24576);     // q clips low
    send_word(16'sd32767, 16'sd32767, 16'd57344);     // q clips high
    send_word(-16'sd32768, -16'sd32768, 16'd57344);
    send_word(16'sd32767, -16'sd32768, 16'd65535);
    send_word(-16'sd32768, 16'sd32767, 16'd1);
    send_word(16'sd20000, -16'sd10000, 16'd16383);
    send_word(16'sd20000, -16'sd10000, 16'd16385);
    send_word(-16'sd12345, 16'sd23456, 16'd32767);
    send_word(-16'sd12345, 16'sd23456, 16'd49151);
    send_word(16'sd30000, 16'sd1000, 16'd63);         // largest fraction of entry 0
    send_word(16'sd30000, 16'sd1000, 16'd64);
    send_word(16'sd30000, 16'sd1000, 16'd100);
    send_word(-16'sd30000, 16'sd5000, 16'h3FC0);      // last table segment
    send_word(-16'sd1, -16'sd1, 16'h5555);
    send_word(16'sd1, 16'sd1, 16'hAAAA);

    for (i = 0; i < N_RANDOM; i++) begin
      if (i >= QUIET_FROM)  idle_en = 1'b0;
      else if (i % 64 == 0) idle_en = ($urandom_range(0, 3) != 0);
      if (i == HOLD_AT) long_hold_req <= 1'b1;
      send_word(pick_current(), pick_current(), pick_angle());
      if (i == DRAIN_AT) begin
        // let the pipeline run dry before offering more
        sample_if.valid <= 1'b0;
        wait (n_matched == n_sent);
        @(posedge clk);
      end else begin
        sender_gap();
      end
    end
    sample_if.valid <= 1'b0;

    wait (n_matched == n_sent);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("%0d sample words: extremes, quadrant edges, table fractions, clipping,",
             n_sent);
    $display("stalls on both sides, a full-pipeline hold and a drain; %0d results checked",
             n_matched);
    if (n_errors == 0 && n_matched == n_sent)
      $display("tb_clarke_park_current_transform: done, clean");
    else
      $display("tb_clarke_park_current_transform: done, errors");
    $finish;
  end

endmodule
